[sv/srot_pkg.sv]
package srot_pkg;

   // default geometry of the receive ring
   localparam int NUM_BUFFERS_DEF      = 8;
   localparam int STRIDES_LOG_DEF      = 6;
   localparam int STRIDE_BYTES_LOG_DEF = 6;

   // fixed field widths
   localparam int FUNC_W     = 2;
   localparam int BUFID_W    = 3;
   localparam int OFF_W      = 6;
   localparam int LEN_W      = 13;
   localparam int ADDR_W     = 48;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // request kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_DATA   = 2'd0,
      FUNC_NOP    = 2'd1,
      FUNC_TAKE   = 2'd2,
      FUNC_REPOST = 2'd3
   } func_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // one captured request
   typedef struct packed {
      func_type             func;
      logic [BUFID_W-1:0]   buffer_id;
      logic [OFF_W-1:0]     stride_offset;
      logic [LEN_W-1:0]     msg_bytes;
      logic                 consumed;
   } req_type;

endpackage

[sv/srot_ram.sv]
module srot_ram #(
   parameter int WIDTH = srot_pkg::LEN_W,
   parameter int DEPTH = srot_pkg::NUM_BUFFERS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/strided_receive_order_tracker.sv]
// Result path: the request is captured and the mark memory read at the request transfer;
// the update state writes the memories and loads the result once the output is free.
// Requests: a new one is taken only in the idle state, after the read-modify-write of the
// mark and entry memories for the last; a stalled result holds the update state.
// Reset: synchronous, active high; head, repost pointer, freed flags, mark rows and base
// address clear at once, with no clearing pass over the memories.
module strided_receive_order_tracker #(
   parameter int NUM_BUFFERS      = srot_pkg::NUM_BUFFERS_DEF,
   parameter int STRIDES_LOG      = srot_pkg::STRIDES_LOG_DEF,
   parameter int STRIDE_BYTES_LOG = srot_pkg::STRIDE_BYTES_LOG_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write: base_address
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srot_pkg::ADDR_W-1:0]       csr_data,
   // requests
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // buffer_id, stride_offset, msg_bytes, consumed
   input  logic [srot_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic [srot_pkg::FUNC_W-1:0]       req_tuser,
   // results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // msg_address, out_bytes, reposted_buffer
   output logic [srot_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // ready_res
   output logic [0:0]                        rsp_tuser
);

   localparam int STRIDES  = 1 << STRIDES_LOG;
   localparam int RING_POS = NUM_BUFFERS * STRIDES;
   localparam int BUF_W    = $clog2(NUM_BUFFERS);
   localparam int POS_W    = BUF_W + STRIDES_LOG;
   localparam int LEN_W    = srot_pkg::LEN_W;
   localparam int ADDR_W   = srot_pkg::ADDR_W;
   localparam int RND_W    = LEN_W + 1;
   localparam int CNT_W    = (RND_W - STRIDE_BYTES_LOG > STRIDES_LOG + 1) ?
                             RND_W - STRIDE_BYTES_LOG : STRIDES_LOG + 1;
   localparam int ENT_W    = LEN_W + CNT_W;
   localparam int SUM_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
   localparam int WRAPS    = (1 << CNT_W) / RING_POS + 1;

   srot_pkg::state_type state_ff, state_in;
   srot_pkg::req_type   req_ff, req_in, req_port, cur_req;

   logic [POS_W-1:0]       head_ff, head_in;
   logic [BUF_W-1:0]       rptr_ff, rptr_in;
   logic [NUM_BUFFERS-1:0] row_valid_ff, row_valid_in;
   logic [NUM_BUFFERS-1:0] freed_ff, freed_in;
   logic [ADDR_W-1:0]      base_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [srot_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [0:0]                        rsp_user_ff, rsp_user_in;

   logic               mark_we;
   logic [BUF_W-1:0]   mark_wr_addr, mark_rd_addr;
   logic [STRIDES-1:0] mark_wr_data, mark_rd_data;
   logic               ent_we;
   logic [POS_W-1:0]   ent_wr_addr;
   logic [ENT_W-1:0]   ent_wr_data, ent_rd_data;

   logic [BUF_W-1:0]       req_buf, head_buf, row_idx;
   logic [STRIDES_LOG-1:0] head_off;
   logic                   in_range, take_hit, out_ok;
   logic [STRIDES-1:0]     row_cur;
   logic [RND_W-1:0]       bytes_rnd;
   logic [CNT_W-1:0]       cnt_calc;
   logic [SUM_W-1:0]       sum;
   logic [ADDR_W-1:0]      take_addr;

   // unpack the request transfer
   always_comb begin
      req_port.func          = srot_pkg::func_type'(req_tuser);
      req_port.buffer_id     = req_tdata[2:0];
      req_port.stride_offset = req_tdata[8:3];
      req_port.msg_bytes     = req_tdata[21:9];
      req_port.consumed      = req_tdata[22];
   end

   assign head_buf = head_ff[POS_W-1 -: BUF_W];
   assign head_off = head_ff[STRIDES_LOG-1:0];
   assign req_buf  = BUF_W'(req_ff.buffer_id);
   assign in_range = 32'(req_ff.buffer_id) < NUM_BUFFERS;

   // the mark read address follows the port while idle, the held request otherwise; a take reads the head row
   assign cur_req      = (state_ff == srot_pkg::ST_IDLE) ? req_port : req_ff;
   assign mark_rd_addr = (cur_req.func == srot_pkg::FUNC_TAKE) ? head_buf :
                         BUF_W'(cur_req.buffer_id);

   // mark rows: a row whose valid bit is clear reads as all zero
   assign row_idx  = (req_ff.func == srot_pkg::FUNC_TAKE) ? head_buf : req_buf;
   assign row_cur  = row_valid_ff[row_idx] ? mark_rd_data : '0;
   assign take_hit = row_cur[head_off];

   // stride count of a data completion
   always_comb begin
      bytes_rnd = {1'b0, req_ff.msg_bytes} + RND_W'((1 << STRIDE_BYTES_LOG) - 1);
      cnt_calc  = CNT_W'(bytes_rnd >> STRIDE_BYTES_LOG);
      if (cnt_calc == '0) begin
         cnt_calc = CNT_W'(1);
      end
      if (req_ff.consumed) begin
         cnt_calc = CNT_W'(STRIDES) - CNT_W'(req_ff.stride_offset);
      end
   end

   // head advance modulo the ring
   always_comb begin
      sum = SUM_W'(head_ff) + SUM_W'(ent_rd_data[ENT_W-1:LEN_W]);
      for (int i = 0; i < WRAPS; i++) begin
         if (sum >= SUM_W'(RING_POS)) begin
            sum = sum - SUM_W'(RING_POS);
         end
      end
   end

   assign take_addr = base_ff + (ADDR_W'(head_ff) << STRIDE_BYTES_LOG);
   assign out_ok    = !rsp_valid_ff || rsp_tready;

   // sequencer and read-modify-write of the state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      rptr_in      = rptr_ff;
      row_valid_in = row_valid_ff;
      freed_in     = freed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mark_we      = 1'b0;
      mark_wr_addr = row_idx;
      mark_wr_data = row_cur;
      ent_we       = 1'b0;
      ent_wr_addr  = {req_buf, STRIDES_LOG'(req_ff.stride_offset)};
      ent_wr_data  = {cnt_calc, req_ff.msg_bytes};
      unique case (state_ff)
         srot_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               req_in   = req_port;
               state_in = srot_pkg::ST_EXEC;
            end
         end
         srot_pkg::ST_EXEC: begin
            if (out_ok) begin
               state_in     = srot_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = '0;
               unique case (req_ff.func)
                  srot_pkg::FUNC_DATA: begin
                     if (in_range) begin
                        mark_we               = 1'b1;
                        mark_wr_data          = row_cur |
                                                (STRIDES'(1) << req_ff.stride_offset);
                        row_valid_in[req_buf] = 1'b1;
                        ent_we                = 1'b1;
                        if (req_ff.consumed) begin
                           freed_in[req_buf] = 1'b1;
                        end
                     end
                  end
                  srot_pkg::FUNC_NOP: begin
                     if (in_range) begin
                        freed_in[req_buf] = 1'b1;
                        if (head_buf == req_buf && head_off != '0) begin
                           if (head_buf == BUF_W'(NUM_BUFFERS - 1)) begin
                              head_in = '0;
                           end else begin
                              head_in = {BUF_W'(head_buf + BUF_W'(1)),
                                         {STRIDES_LOG{1'b0}}};
                           end
                        end
                     end
                  end
                  srot_pkg::FUNC_TAKE: begin
                     if (take_hit) begin
                        mark_we      = 1'b1;
                        mark_wr_data = row_cur & ~(STRIDES'(1) << head_off);
                        head_in      = POS_W'(sum);
                        rsp_user_in  = 1'b1;
                        rsp_data_in  = {3'd0, ent_rd_data[LEN_W-1:0], take_addr};
                     end
                  end
                  srot_pkg::FUNC_REPOST: begin
                     if (freed_ff[rptr_ff]) begin
                        row_valid_in[rptr_ff] = 1'b0;
                        freed_in[rptr_ff]     = 1'b0;
                        rsp_user_in           = 1'b1;
                        rsp_data_in           = {3'(rptr_ff), {(LEN_W + ADDR_W){1'b0}}};
                        if (rptr_ff == BUF_W'(NUM_BUFFERS - 1)) begin
                           rptr_in = '0;
                        end else begin
                           rptr_in = rptr_ff + BUF_W'(1);
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = srot_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srot_pkg::ST_IDLE;
         head_ff      <= '0;
         rptr_ff      <= '0;
         row_valid_ff <= '0;
         freed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rptr_ff      <= rptr_in;
         row_valid_ff <= row_valid_in;
         freed_ff     <= freed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            base_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // arrived marks, one row per buffer
   srot_ram #(
      .WIDTH (STRIDES),
      .DEPTH (NUM_BUFFERS)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

   // stride count and length per ring position
   srot_ram #(
      .WIDTH (ENT_W),
      .DEPTH (RING_POS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (head_ff),
      .rd_data (ent_rd_data)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == srot_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a request transfer is always followed by the update cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == srot_pkg::ST_EXEC)
      else $error("request transfer not followed by update cycle");

   // a new result only appears out of the update cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == srot_pkg::ST_EXEC))
      else $error("result raised outside the update cycle");

   // memories are written only in the update cycle
   assert property (@(posedge clock) disable iff (reset)
      mark_we || ent_we |-> state_ff == srot_pkg::ST_EXEC)
      else $error("memory write outside the update cycle");

   // head stays inside the ring
   assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < RING_POS)
      else $error("head position out of ring");

   // repost pointer stays inside the buffer range
   assert property (@(posedge clock) disable iff (reset)
      32'(rptr_ff) < NUM_BUFFERS)
      else $error("repost pointer out of range");

endmodule
